// ===== hdl/assert_macros.svh =====
// Assertion macros used by json_syntax_validator.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== hdl/jsv_pkg.sv =====
// Package for the JSON syntax validator: parse modes, kinds, constants.
// No dependencies.
`timescale 1ns / 1ps
package jsv_pkg;
	localparam int JSV_MAX_DEPTH = 16;

	typedef enum logic [4:0] {
		M_VALUE, M_ARR_FIRST, M_OBJ_FIRST, M_KEY, M_COLON, M_AFTER,
		M_VSTR, M_VESC, M_VHEX, M_KSTR, M_KESC, M_KHEX, M_LIT,
		N_MINUS, N_ZERO, N_INT, N_DOT, N_FRAC, N_E, N_ESIGN, N_EXP
	} mode_t;

	typedef enum logic [2:0] {
		K_OBJ = 3'd0, K_ARR = 3'd1, K_STR = 3'd2, K_NUM = 3'd3,
		K_TRUE = 3'd4, K_FALSE = 3'd5, K_NULL = 3'd6, K_NONE = 3'd7
	} kind_t;

	localparam logic [1:0] ROOT_OBJ = 2'd0;
	localparam logic [1:0] ROOT_ARR = 2'd1;

	localparam logic [1:0] LIT_TRUE  = 2'd0;
	localparam logic [1:0] LIT_FALSE = 2'd1;
	localparam logic [1:0] LIT_NULL  = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic       valid_res;
		logic [2:0] root_kind;
	} out_item_t;

	// literal byte at position idx; 0 past the end
	function automatic logic [7:0] lit_char(input logic [1:0] sel, input logic [2:0] idx);
		logic [7:0] c;
		c = 8'h00;
		case (sel)
			LIT_FALSE: begin
				case (idx)
					3'd0: c = "f";
					3'd1: c = "a";
					3'd2: c = "l";
					3'd3: c = "s";
					3'd4: c = "e";
					default: c = 8'h00;
				endcase
			end
			LIT_NULL: begin
				case (idx)
					3'd0: c = "n";
					3'd1: c = "u";
					3'd2: c = "l";
					3'd3: c = "l";
					default: c = 8'h00;
				endcase
			end
			default: begin
				case (idx)
					3'd0: c = "t";
					3'd1: c = "r";
					3'd2: c = "u";
					3'd3: c = "e";
					default: c = 8'h00;
				endcase
			end
		endcase
		return c;
	endfunction

	function automatic logic [2:0] lit_len(input logic [1:0] sel);
		return (sel == LIT_FALSE) ? 3'd5 : 3'd4;
	endfunction
endpackage

// ===== hdl/jsv_stream_if.sv =====
// Valid/ready stream interface with a typed payload.
// Depends on nothing but the payload type given as parameter.
`timescale 1ns / 1ps
interface jsv_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/json_syntax_validator.sv =====
// Top level of the JSON syntax validator.
// Depends on jsv_pkg, jsv_stream_if, jsv_ram and assert_macros.svh.
//
//  channel   dir   payload                 handshake
//  in_ch     sink  data_byte, last         valid/ready
//  out_ch    src   valid_res, root_kind    valid/ready
//  cfg       in    required_root           cfg_we
//
// One byte per cycle; the result shows up the cycle after the last byte.
// The container stack sits in a RAM; the kind of the innermost open container
// is held in a register, and after a pop the new top is read from entry
// depth-1 and forwarded the next cycle, so no stall is needed.
// Input stalls only while a result waits and the output is not taken.
// arst_n clears all control state; the stack needs no clearing.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module json_syntax_validator #(
	parameter int MAX_DEPTH = jsv_pkg::JSV_MAX_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	jsv_stream_if.sink   in_ch,
	jsv_stream_if.source out_ch,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata
);
	import jsv_pkg::*;

	localparam int SDEPTH = MAX_DEPTH + 1;
	localparam int AW = $clog2(SDEPTH);
	localparam int DW = $clog2(MAX_DEPTH + 2);

	mode_t        mode_q, mode_d;
	logic [DW-1:0] depth_q, depth_d;
	logic [2:0]   sub_q, sub_d;
	logic [1:0]   lsel_q, lsel_d;
	logic         failed_q, failed_d;
	logic [2:0]   root_q, root_d;
	logic [1:0]   req_q;
	logic         top_q;  // innermost container is an object (forwarded copy)
	logic         top_fwd_q;
	logic         out_valid_q;
	out_item_t    out_q;
	out_item_t    out_item_result;

	logic         push, pop, push_obj;
	logic         ram_rd;
	logic [AW-1:0] raddr;
	logic         top_obj;
	logic [7:0]   b;
	logic         acc;

	assign b = in_ch.payload.data_byte;
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign acc = in_ch.valid && in_ch.ready;
	assign out_ch.valid = out_valid_q;
	assign out_ch.payload = out_q;

	// after a pop the new top comes from RAM, otherwise the held copy
	assign top_obj = top_fwd_q ? ram_rd : top_q;

	// read entry depth_d-1: the new top after a pop
	always_comb begin
		if (depth_d >= DW'(1)) begin
			raddr = AW'(depth_d - DW'(1));
		end else begin
			raddr = '0;
		end
	end

	jsv_ram #(.WIDTH(1), .DEPTH(SDEPTH)) u_stack (
		.clk   (clk),
		.we    (acc && push),
		.waddr (AW'(depth_q)),
		.wdata (push_obj),
		.raddr (raddr),
		.rdata (ram_rd)
	);

	function automatic logic is_dig(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	always_comb begin
		logic ws, dig, hex, e, consumed, tobj, can_end, ok;
		logic [2:0] kind, ns;
		mode_t m;
		mode_d = mode_q; depth_d = depth_q; sub_d = sub_q; lsel_d = lsel_q;
		failed_d = failed_q; root_d = root_q;
		push = 1'b0; pop = 1'b0; push_obj = 1'b0;
		ws = b == 8'h20 || b == 8'h09 || b == 8'h0d || b == 8'h0a;
		dig = is_dig(b);
		hex = dig || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
		e = b == "e" || b == "E";
		consumed = 1'b0;
		kind = K_NONE;
		ns = 3'd0;
		tobj = top_obj;
		m = mode_q;
		if (!failed_q) begin
			if (mode_q >= N_MINUS) begin
				consumed = 1'b1;
				case (mode_q)
					N_MINUS: if (b == "0") mode_d = N_ZERO; else if (dig) mode_d = N_INT;
						else failed_d = 1'b1;
					N_DOT: if (dig) mode_d = N_FRAC; else failed_d = 1'b1;
					N_E: if (b == "+" || b == "-") mode_d = N_ESIGN;
						else if (dig) mode_d = N_EXP; else failed_d = 1'b1;
					N_ESIGN: if (dig) mode_d = N_EXP; else failed_d = 1'b1;
					N_ZERO: if (dig) failed_d = 1'b1; else if (b == ".") mode_d = N_DOT;
						else if (e) mode_d = N_E; else consumed = 1'b0;
					N_INT: if (dig) ; else if (b == ".") mode_d = N_DOT;
						else if (e) mode_d = N_E; else consumed = 1'b0;
					N_FRAC: if (dig) ; else if (e) mode_d = N_E; else consumed = 1'b0;
					default: consumed = dig;
				endcase
				if (!consumed) begin
					m = M_AFTER;
					mode_d = M_AFTER;
				end
			end
			if (!consumed && !(ws && m <= M_AFTER)) begin
				case (m)
					M_VALUE, M_ARR_FIRST, M_OBJ_FIRST, M_KEY, M_COLON, M_AFTER: begin
						if (m == M_ARR_FIRST && b == "]") begin
							pop = 1'b1;
						end else if (m == M_OBJ_FIRST && b == "}") begin
							pop = 1'b1;
						end else if (m == M_OBJ_FIRST || m == M_KEY) begin
							if (b == "\"") mode_d = M_KSTR; else failed_d = 1'b1;
						end else if (m == M_COLON) begin
							if (b == ":") mode_d = M_VALUE; else failed_d = 1'b1;
						end else if (m == M_AFTER) begin
							if (depth_q == '0 || 32'(depth_q) > MAX_DEPTH + 1) failed_d = 1'b1;
							else if (b == ",") mode_d = tobj ? M_KEY : M_VALUE;
							else if (b == (tobj ? 8'h7d : 8'h5d)) pop = 1'b1;
							else failed_d = 1'b1;
						end else begin
							// start of a value
							if (32'(depth_q) > MAX_DEPTH) failed_d = 1'b1;
							else begin
								if (b == "\"") begin kind = K_STR; mode_d = M_VSTR; end
								else if (b == "{" || b == "[") begin
									kind = (b == "{") ? K_OBJ : K_ARR;
									push = 1'b1; push_obj = b == "{";
									mode_d = (b == "{") ? M_OBJ_FIRST : M_ARR_FIRST;
								end else if (b == "t" || b == "f" || b == "n") begin
									lsel_d = (b == "t") ? LIT_TRUE : (b == "f") ? LIT_FALSE : LIT_NULL;
									kind = (b == "t") ? K_TRUE : (b == "f") ? K_FALSE : K_NULL;
									sub_d = 3'd1; mode_d = M_LIT;
								end else if (b == "-") begin kind = K_NUM; mode_d = N_MINUS; end
								else if (b == "0") begin kind = K_NUM; mode_d = N_ZERO; end
								else if (dig) begin kind = K_NUM; mode_d = N_INT; end
								else failed_d = 1'b1;
								if (!failed_d && (depth_q == '0 ||
									(depth_q == DW'(1) && kind <= K_ARR)) && root_q == K_NONE)
									root_d = kind;
							end
						end
						if (pop) begin
							depth_d = depth_q - DW'(1);
							mode_d = M_AFTER;
						end
						if (push) depth_d = depth_q + DW'(1);
					end
					M_VSTR, M_KSTR: begin
						if (b == "\"") mode_d = (m == M_VSTR) ? M_AFTER : M_COLON;
						else if (b < 8'h20) failed_d = 1'b1;
						else if (b == "\\") mode_d = (m == M_VSTR) ? M_VESC : M_KESC;
					end
					M_VESC, M_KESC: begin
						if (b == "u") begin
							sub_d = 3'd0; mode_d = (m == M_VESC) ? M_VHEX : M_KHEX;
						end else if (b == "\"" || b == "\\" || b == "/" || b == "b" ||
							b == "f" || b == "n" || b == "r" || b == "t")
							mode_d = (m == M_VESC) ? M_VSTR : M_KSTR;
						else failed_d = 1'b1;
					end
					M_VHEX, M_KHEX: begin
						if (!hex) failed_d = 1'b1;
						else if (sub_q >= 3'd3) begin
							sub_d = 3'd0; mode_d = (m == M_VHEX) ? M_VSTR : M_KSTR;
						end else sub_d = sub_q + 3'd1;
					end
					M_LIT: begin
						if (sub_q < lit_len(lsel_q) && b == lit_char(lsel_q, sub_q)) begin
							ns = sub_q + 3'd1;
							if (ns >= lit_len(lsel_q)) begin
								sub_d = 3'd0; mode_d = M_AFTER;
							end else sub_d = ns;
						end else failed_d = 1'b1;
					end
					default: failed_d = 1'b1;
				endcase
			end
		end
		can_end = mode_d == M_AFTER || mode_d == N_ZERO || mode_d == N_INT ||
			mode_d == N_FRAC || mode_d == N_EXP;
		ok = !failed_d && depth_d == '0 && can_end;
		if (ok && req_q <= ROOT_ARR && root_d != {1'b0, req_q}) ok = 1'b0;
		out_item_result = '{valid_res: ok, root_kind: root_d};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_VALUE; depth_q <= '0; sub_q <= '0; lsel_q <= '0;
			failed_q <= 1'b0; root_q <= K_NONE; req_q <= ROOT_OBJ;
			top_q <= 1'b0; top_fwd_q <= 1'b0; out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) req_q <= cfg_wdata;
			out_valid_q <= (acc && in_ch.payload.last) || (out_valid_q && !out_ch.ready);
			if (acc) begin
				if (in_ch.payload.last) begin
					mode_q <= M_VALUE; depth_q <= '0; sub_q <= '0; lsel_q <= '0;
					failed_q <= 1'b0; root_q <= K_NONE; top_fwd_q <= 1'b0;
				end else begin
					mode_q <= mode_d; depth_q <= depth_d; sub_q <= sub_d;
					lsel_q <= lsel_d; failed_q <= failed_d; root_q <= root_d;
					top_fwd_q <= pop;
					if (push) top_q <= push_obj;
					else if (pop) top_q <= 1'b0;
					else top_q <= top_obj;
				end
			end else begin
				top_q <= top_obj;
				top_fwd_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && in_ch.payload.last) out_q <= out_item_result;
	end

	`ASSERT_IMP(a_depth_range, clk, arst_n, 1'b1, 32'(depth_q) <= MAX_DEPTH + 1,
		"stack depth out of range")
	`ASSERT_NEXT(a_last_gives_result, clk, arst_n, acc && in_ch.payload.last,
		out_valid_q, "last item gave no result")
	`ASSERT_NEXT(a_reset_after_last, clk, arst_n, acc && in_ch.payload.last,
		depth_q == '0 && root_q == K_NONE && !failed_q, "parser not cleared after last")
endmodule

// ===== hdl/jsv_ram.sv =====
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module jsv_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
